// ===== hdl/mbd_pkg.sv =====
package mbd_pkg;

	localparam int BUTTONS     = 8;
	localparam int TIME_W      = 32;
	localparam int RAW_W       = 8;
	localparam int DEB_W       = 16;
	localparam int IDS_W       = 64;
	localparam int ID_W        = 8;
	localparam int IDX_W       = 3;
	localparam int CODE_W      = 9;
	localparam int DATA_W      = 64;
	localparam int ADDR_W      = 5;
	localparam int REG_SEL_LSB = 3;

	localparam logic [CODE_W-1:0] SOUND_OFFSET = CODE_W'(4);
	localparam logic [DEB_W-1:0]  DEB_RESET    = DEB_W'(50);

	typedef enum logic [1:0] {
		REG_INPUT_ENABLE = 2'd0,
		REG_DEBOUNCE_MS  = 2'd1,
		REG_SOUND_IDS    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              input_enable;
		logic [DEB_W-1:0]  debounce_ms;
		logic [IDS_W-1:0]  sound_ids;
	} cfg_t;

endpackage

// ===== hdl/mbd_if.sv =====
interface mbd_poll_if;
	logic                       valid;
	logic                       ready;
	logic [mbd_pkg::TIME_W-1:0] now_ms;
	logic [mbd_pkg::RAW_W-1:0]  raw_pressed;

	modport source (output valid, output now_ms, output raw_pressed, input ready);
	modport sink   (input valid, input now_ms, input raw_pressed, output ready);
endinterface

interface mbd_event_if;
	logic                       valid;
	logic                       ready;
	logic [mbd_pkg::IDX_W-1:0]  button_index;
	logic [mbd_pkg::CODE_W-1:0] sound_code;
	logic                       last_event;

	modport source (output valid, output button_index, output sound_code, output last_event,
		input ready);
	modport sink   (input valid, input button_index, input sound_code, input last_event,
		output ready);
endinterface

// ===== hdl/mbd_cfg.sv =====
module mbd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
	output logic [mbd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output mbd_pkg::cfg_t               cfg
);
	import mbd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr;

	assign sel    = reg_idx_t'(paddr[ADDR_W-1:REG_SEL_LSB]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_enable <= 1'b1;
			cfg_q.debounce_ms  <= DEB_RESET;
			cfg_q.sound_ids    <= '0;
		end else if (wr) begin
			case (sel)
				REG_INPUT_ENABLE: cfg_q.input_enable <= pwdata[0];
				REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= pwdata[DEB_W-1:0];
				REG_SOUND_IDS:    cfg_q.sound_ids    <= pwdata[IDS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_INPUT_ENABLE: prdata = DATA_W'(cfg_q.input_enable);
			REG_DEBOUNCE_MS:  prdata = DATA_W'(cfg_q.debounce_ms);
			REG_SOUND_IDS:    prdata = DATA_W'(cfg_q.sound_ids);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== hdl/mbd_lane.sv =====
module mbd_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [mbd_pkg::TIME_W-1:0]  now_ms,
	input  logic                        raw,
	input  logic [mbd_pkg::DEB_W-1:0]   debounce_ms,
	output logic                        press
);
	import mbd_pkg::*;

	logic              last_raw_q;
	logic              stable_q;
	logic [TIME_W-1:0] change_time_q;
	logic [TIME_W-1:0] change_time_d;
	logic [TIME_W-1:0] elapsed;
	logic              settled;
	logic              flip;

	// restart the hold window on any raw edge, then compare wrapped age
	assign change_time_d = (raw != last_raw_q) ? now_ms : change_time_q;
	assign elapsed       = now_ms - change_time_d;
	assign settled       = elapsed >= TIME_W'(debounce_ms);
	assign flip          = settled && (stable_q != raw);
	assign press         = step && flip && raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			change_time_q <= '0;
		end else if (step) begin
			last_raw_q    <= raw;
			change_time_q <= change_time_d;
			if (flip)
				stable_q <= raw;
		end
	end

endmodule

// ===== hdl/mbd_merge.sv =====
module mbd_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [mbd_pkg::BUTTONS-1:0] press_mask,
	input  logic [mbd_pkg::IDS_W-1:0]   sound_ids,
	output logic                        can_load,
	mbd_event_if.source                 evt
);
	import mbd_pkg::*;

	logic [BUTTONS-1:0] pend_q;
	logic [BUTTONS-1:0] pick;
	logic [BUTTONS-1:0] pend_left;
	logic [IDX_W-1:0]   pick_idx;
	logic               take;
	logic               out_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CODE_W-1:0]  code_q;
	logic               last_q;

	// lowest pending button goes first
	always_comb begin
		pick     = '0;
		pick_idx = '0;
		for (int i = BUTTONS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				pick     = '0;
				pick[i]  = 1'b1;
				pick_idx = IDX_W'(i);
			end
		end
	end

	assign take      = (pend_q != '0) && (!out_valid_q || evt.ready);
	assign pend_left = take ? (pend_q & ~pick) : pend_q;
	assign can_load  = (pend_left == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= load ? press_mask : pend_left;
			if (take)
				out_valid_q <= 1'b1;
			else if (evt.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q  <= pick_idx;
			code_q <= CODE_W'(sound_ids[ID_W*pick_idx +: ID_W]) + SOUND_OFFSET;
			last_q <= ((pend_q & ~pick) == '0);
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.button_index = idx_q;
	assign evt.sound_code   = code_q;
	assign evt.last_event   = last_q;

endmodule

// ===== hdl/multi_button_debounce_press_events.sv =====
// Debounces BUTTONS push buttons polled at millisecond pace and reports new
// presses. Each poll beat carries a timestamp and the raw pressed levels; on
// acceptance every button lane updates its last raw level, change time and
// stable level in that same cycle (wrapping 32-bit age against debounce_ms),
// and the lanes' press flags land in a pending mask. Events then leave one per
// cycle while the sink is ready, lowest button first, with last_event on the
// final one of the poll; a poll that yields no press emits nothing. A poll
// with k presses (at most 8) holds off the next poll until its events are all
// staged; the next poll is taken in the cycle the final event moves into the
// output register, so polls run at one per cycle when each causes at most one
// press and the sink keeps up. The output register lets a new poll enter
// while an event waits for its sink. With input_enable low, polls are
// accepted and dropped with no state change. Registers sit on an APB port,
// 64-bit data, byte address 8*index: input_enable, debounce_ms, sound_ids.
// Change the registers only while no events are pending.
module multi_button_debounce_press_events (
	input  logic                        clk,
	input  logic                        arst_n,
	mbd_poll_if.sink                    poll,
	mbd_event_if.source                 evt,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0]  paddr,
	input  logic [mbd_pkg::DATA_W-1:0]  pwdata,
	output logic [mbd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import mbd_pkg::*;

	cfg_t               cfg;
	logic               accept;
	logic               step;
	logic               can_load;
	logic [BUTTONS-1:0] press_mask;

	mbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// take a poll once the previous poll's events are all staged
	assign poll.ready = can_load;
	assign accept     = poll.valid && poll.ready;
	// a disabled poll is swallowed without touching lane state
	assign step       = accept && cfg.input_enable;

	for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
		mbd_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.step        (step),
			.now_ms      (poll.now_ms),
			.raw         (poll.raw_pressed[g]),
			.debounce_ms (cfg.debounce_ms),
			.press       (press_mask[g])
		);
	end

	// merge lane flags and drain them in button order
	mbd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.press_mask (press_mask),
		.sound_ids  (cfg.sound_ids),
		.can_load   (can_load),
		.evt        (evt)
	);

endmodule

// ===== tb/mbd_press_monitor.sv =====
`timescale 1ns / 1ps

module mbd_press_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	mbd_poll_if                        poll,
	mbd_event_if                       evt,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [mbd_pkg::ADDR_W-1:0] paddr,
	input  logic [mbd_pkg::DATA_W-1:0] pwdata,
	output int                         mismatches,
	output int                         presses_due
);
	import mbd_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]  button_index;
		logic [CODE_W-1:0] sound_code;
		logic              last_event;
	} press_t;

	cfg_t               regs;
	logic [BUTTONS-1:0] raw_seen;
	logic [BUTTONS-1:0] stable;
	logic [TIME_W-1:0]  changed_at [BUTTONS];
	press_t             due_presses [$];
	press_t             seen;
	press_t             want;

	// Update the per-button debounce state for one poll and queue its presses.
	task automatic debounce_poll(input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw);
		press_t            batch [BUTTONS];
		int                n;
		logic [TIME_W-1:0] age;
		logic              lvl;
		n = 0;
		if (regs.input_enable) begin
			for (int b = 0; b < BUTTONS; b++) begin
				lvl = raw[b];
				if (lvl != raw_seen[b]) begin
					raw_seen[b]   = lvl;
					changed_at[b] = now;
				end
				age = now - changed_at[b];
				if (age >= TIME_W'(regs.debounce_ms) && lvl != stable[b]) begin
					stable[b] = lvl;
					if (lvl) begin
						batch[n].button_index = IDX_W'(b);
						batch[n].sound_code   = CODE_W'(regs.sound_ids[b*ID_W +: ID_W])
							+ SOUND_OFFSET;
						batch[n].last_event   = 1'b0;
						n++;
					end
				end
			end
			for (int k = 0; k < n; k++) begin
				if (k == n - 1)
					batch[k].last_event = 1'b1;
				due_presses.push_back(batch[k]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.input_enable = 1'b1;
			regs.debounce_ms  = DEB_RESET;
			regs.sound_ids    = '0;
			raw_seen          = '0;
			stable            = '0;
			for (int b = 0; b < BUTTONS; b++)
				changed_at[b] = '0;
			due_presses.delete();
			presses_due = 0;
			mismatches  = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:REG_SEL_LSB])
					REG_INPUT_ENABLE: regs.input_enable = pwdata[0];
					REG_DEBOUNCE_MS:  regs.debounce_ms  = pwdata[DEB_W-1:0];
					REG_SOUND_IDS:    regs.sound_ids    = pwdata[IDS_W-1:0];
					default: ;
				endcase
			end
			if (poll.valid && poll.ready)
				debounce_poll(poll.now_ms, poll.raw_pressed);
			if (evt.valid && evt.ready) begin
				seen = {evt.button_index, evt.sound_code, evt.last_event};
				if (due_presses.size() == 0) begin
					$display("%0t: unexpected press event: button %0d code %0d last %0b",
						$time, seen.button_index, seen.sound_code, seen.last_event);
					mismatches++;
				end else begin
					want = due_presses.pop_front();
					if (seen !== want) begin
						$display({"%0t: press event mismatch: expected button %0d code %0d",
							" last %0b, actual button %0d code %0d last %0b"}, $time,
							want.button_index, want.sound_code, want.last_event,
							seen.button_index, seen.sound_code, seen.last_event);
						mismatches++;
					end
				end
			end
			presses_due = due_presses.size();
		end
	end

endmodule

// ===== tb/multi_button_debounce_press_events_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the button debouncer. The monitor beside the
// block mirrors the register writes, predicts press events per poll beat and
// compares every event beat; this module only drives and decides.
module multi_button_debounce_press_events_test;
	import mbd_pkg::*;

	// Longest stretch with no beat on either channel before the run is aborted.
	// A correct run idles only for a sender gap, a receiver stall, settle time
	// and up to three register writes in a row.
	localparam int         IDLE_LIMIT    = 1000;
	// Polls are absorbed in their accept cycle; allow a margin for the event path.
	localparam int         SETTLE_CYCLES = 8;
	localparam int         PHASE_POLLS   = 50;
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// When set, neither side inserts idle cycles.
	logic              no_idle;
	logic [TIME_W-1:0] t_ms;
	logic [RAW_W-1:0]  levels;
	int                mismatches;
	int                presses_due;
	int                idle_cycles = 0;

	mbd_poll_if  poll_ch ();
	mbd_event_if evt_ch ();

	multi_button_debounce_press_events uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_ch),
		.evt     (evt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mbd_press_monitor press_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll        (poll_ch),
		.evt         (evt_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.presses_due (presses_due)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] reg_addr(input logic [1:0] idx);
		return ADDR_W'(idx) << REG_SEL_LSB;
	endfunction

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge where the access phase meets pready.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Present one poll beat after a random gap and hold it until accepted.
	// valid gets at most one assignment per falling edge, so back-to-back
	// beats keep it high.
	task automatic send_poll(input logic [TIME_W-1:0] now, input logic [RAW_W-1:0] raw);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			poll_ch.valid <= 1'b0;
		end
		@(negedge clk);
		poll_ch.valid       <= 1'b1;
		poll_ch.now_ms      <= now;
		poll_ch.raw_pressed <= raw;
		do @(posedge clk); while (!poll_ch.ready);
	endtask

	// Drop valid, wait until every predicted press has left, then let the
	// block run dry. Register writes only follow this.
	task automatic settle();
		@(negedge clk);
		poll_ch.valid <= 1'b0;
		while (presses_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random walk of raw levels: about half the polls hold the levels so that
	// changes survive the debounce window, the rest flip a sparse set of
	// buttons (bounce) or scramble all of them. Time steps are scaled to the
	// debounce so that both sides of the threshold are hit, with an occasional
	// full 32-bit jump to wrap the clock.
	task automatic random_polls(input int count, input int deb);
		logic [TIME_W-1:0] step;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0:          step = '0;
				1, 2, 3, 4: step = $urandom_range(0, deb / 2 + 1);
				5, 6:       step = deb + $urandom_range(0, 3);
				default:    step = $urandom;
			endcase
			if ($urandom_range(0, 15) == 0)
				levels = RAW_W'($urandom);
			else if ($urandom_range(0, 1) == 1)
				levels = levels ^ RAW_W'($urandom & $urandom);
			t_ms = t_ms + step;
			send_poll(t_ms, levels);
			// Hold the sender now and then until all presses have drained.
			if ($urandom_range(0, 31) == 0)
				settle();
		end
	endtask

	// Event sink: draw a stall for every beat, then hold ready until it moves.
	initial begin
		evt_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = no_idle ? 0 : $urandom_range(0, 7);
			repeat (stall) begin
				@(negedge clk);
				evt_ch.ready <= 1'b0;
			end
			@(negedge clk);
			evt_ch.ready <= 1'b1;
			do @(posedge clk); while (!evt_ch.valid);
		end
	end

	// Watchdog: abort when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((poll_ch.valid && poll_ch.ready) || (evt_ch.valid && evt_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int deb;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		poll_ch.valid       = 1'b0;
		poll_ch.now_ms      = '0;
		poll_ch.raw_pressed = '0;
		no_idle             = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults, 50 ms debounce: all eight buttons go down together
		// and come out as eight beats, the last one flagged.
		send_poll(32'd0, 8'hFF);
		send_poll(32'd50, 8'hFF);

		// Zero debounce and extreme sound ids (0 and 255 among them): levels
		// are taken on the poll where they appear. Releases emit nothing.
		settle();
		write_reg(reg_addr(REG_SOUND_IDS), 64'hFF00_7F80_0102_FE01);
		write_reg(reg_addr(REG_DEBOUNCE_MS), {$urandom, 16'($urandom), 16'd0});
		send_poll(32'd60, 8'h00);
		send_poll(32'd60, 8'h81);
		send_poll(32'd61, 8'hFF);
		send_poll(32'd61, 8'h7E);

		// Disabled input: polls are taken and dropped, no state moves.
		settle();
		write_reg(reg_addr(REG_INPUT_ENABLE), {$urandom, $urandom} & ~64'd1);
		send_poll(32'd62, 8'h00);
		send_poll(32'd70, 8'hFF);

		// Re-enable, hit the unused register slot, then the longest debounce:
		// just under and exactly at the window, and across the 32-bit wrap.
		settle();
		write_reg(reg_addr(REG_INPUT_ENABLE), {$urandom, $urandom} | 64'd1);
		write_reg(reg_addr(REG_UNUSED), {$urandom, $urandom});
		write_reg(reg_addr(REG_DEBOUNCE_MS), {$urandom, 16'($urandom), 16'hFFFF});
		send_poll(32'd100, 8'h00);
		send_poll(32'd100 + 32'd65535, 8'h00);
		send_poll(32'd100 + 32'd65535, 8'h55);
		send_poll(32'd100 + 32'd131069, 8'h55);
		send_poll(32'd100 + 32'd131070, 8'h55);
		send_poll(32'hFFFF_FFF0, 8'hAA);
		send_poll(32'h0000_FFEF, 8'hAA);

		// Random phases, each with its own debounce and sound ids; one phase
		// runs with no idling on either side.
		t_ms   = 32'h0001_0000;
		levels = 8'hAA;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       deb = 0;
				1:       deb = 1;
				2:       deb = $urandom_range(2, 12);
				3:       deb = 65535;
				4:       deb = $urandom_range(0, 65535);
				default: deb = $urandom_range(3, 8);
			endcase
			settle();
			write_reg(reg_addr(REG_DEBOUNCE_MS), {$urandom, 16'($urandom), 16'(deb)});
			write_reg(reg_addr(REG_SOUND_IDS), {$urandom, $urandom});
			no_idle = (p == 2);
			random_polls(PHASE_POLLS, deb);
		end

		// Disable mid-stream, then resume so that any state leak shows up.
		settle();
		write_reg(reg_addr(REG_INPUT_ENABLE), {$urandom, $urandom} & ~64'd1);
		random_polls(10, deb);
		settle();
		write_reg(reg_addr(REG_INPUT_ENABLE), {$urandom, $urandom} | 64'd1);
		random_polls(10, deb);

		// Drain and give the verdict.
		settle();
		@(negedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mbd_pkg.sv
hdl/mbd_if.sv
hdl/mbd_cfg.sv
hdl/mbd_lane.sv
hdl/mbd_merge.sv
hdl/multi_button_debounce_press_events.sv
tb/mbd_press_monitor.sv
tb/multi_button_debounce_press_events_test.sv
